>>> hdl/median_filter_3x3_rgb_top_defines.svh
// Assertion macros shared by the median filter RTL.
`ifndef MEDIAN_FILTER_3X3_RGB_TOP_DEFINES_SVH
`define MEDIAN_FILTER_3X3_RGB_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define MF3_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mf3 assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is high.
`define MF3_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mf3 assertion failed: next-cycle check");

`endif

>>> hdl/mf3_pkg.sv
// Shared types and constants for the 3x3 RGB median filter.
`default_nettype none

package mf3_pkg;

   localparam int unsigned CHAN_W     = 8;
   localparam int unsigned PIX_W      = 3 * CHAN_W;
   localparam int unsigned TAPS       = 9;
   localparam int unsigned MID_TAP    = 4;
   localparam int unsigned WIDTH_W    = 12;
   localparam int unsigned HEIGHT_W   = 13;
   localparam int unsigned ROW_W      = 12;
   localparam int unsigned MIN_DIM    = 3;
   localparam int unsigned MAX_HEIGHT = 4096;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 13;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1
   } csr_index_type;

   // Per-pixel position flags handed from the frame control to the datapath.
   typedef struct packed {
      logic emit;     // pixel completes an interior window
      logic last;     // last interior pixel of the frame
      logic restart;  // image_width or image_height write: clear window and counters
   } pos_flags_type;

   typedef logic [TAPS-1:0][PIX_W-1:0] window_type;

endpackage

`default_nettype wire

>>> hdl/mf3_ifs.sv
// Channel interfaces: pixel input, median result and register write.
`default_nettype none

interface mf3_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] chan0_in;
   logic [7:0] chan1_in;
   logic [7:0] chan2_in;
   modport source (output valid, output chan0_in, output chan1_in, output chan2_in,
                   input ready);
   modport sink   (input valid, input chan0_in, input chan1_in, input chan2_in,
                   output ready);
endinterface

interface mf3_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] chan0_med;
   logic [7:0] chan1_med;
   logic [7:0] chan2_med;
   logic       frame_last;
   modport source (output valid, output chan0_med, output chan1_med, output chan2_med,
                   output frame_last, input ready);
   modport sink   (input valid, input chan0_med, input chan1_med, input chan2_med,
                   input frame_last, output ready);
endinterface

interface mf3_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [12:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/median_filter_3x3_rgb_top.sv
// Top level of the streaming 3x3 RGB median filter.
`default_nettype none
`include "median_filter_3x3_rgb_top_defines.svh"

// Streaming 3x3 median filter for 24-bit RGB pixels in raster order. One
// pixel transaction is taken per clock, sustained while the result side does
// not stall, and interior pixels come out at the same rate; the line store
// read and stage 1 are registered at the accepting edge, and the result
// register is loaded from stage 1 once the result side can take it. Border
// pixels give no result transaction. The last interior pixel of a frame
// carries frame_last. Writing image_width (index 0) or image_height (index 1)
// restarts the frame: counters and window clear, the line stores keep their
// contents. Widths outside 3..MAX_WIDTH and heights outside 3..4096 are
// clamped. Register writes must only be issued while no pixel is in flight.
module median_filter_3x3_rgb_top #(
   parameter int unsigned MAX_WIDTH = 2048
) (
   input  wire logic clock,
   input  wire logic reset,
   mf3_req_if.sink   req,
   mf3_rsp_if.source rsp,
   mf3_csr_if.sink   csr
);

   localparam int unsigned CW    = $clog2(MAX_WIDTH);
   localparam int unsigned PIX_W = mf3_pkg::PIX_W;

   // Handshake
   logic                     req_accept;
   logic                     out_ready;
   logic                     s1_adv;

   // Frame position of the pixel being accepted
   logic [CW-1:0]            col;
   mf3_pkg::pos_flags_type   flags;

   // Stage 1: pixel waits here while the line store read completes
   logic                     s1_valid_ff;
   logic [PIX_W-1:0]         s1_pix_ff;
   logic [CW-1:0]            s1_col_ff;
   logic                     s1_emit_ff;
   logic                     s1_last_ff;

   // Line store: [47:24] previous row, [23:0] the row before that
   logic [2*PIX_W-1:0]       line_rd;
   logic [2*PIX_W-1:0]       line_wr;

   // Window and result
   mf3_pkg::window_type      window_ff, window_in;
   logic [7:0]               med0, med1, med2;
   logic                     rsp_valid_ff;
   logic [7:0]               rsp_med0_ff, rsp_med1_ff, rsp_med2_ff;
   logic                     rsp_last_ff;

   // Stage 1 moves on whenever the result register is free or being drained.
   assign out_ready  = !rsp_valid_ff || rsp.ready;
   assign s1_adv     = s1_valid_ff && out_ready;
   assign req.ready  = !s1_valid_ff || out_ready;
   assign req_accept = req.valid && req.ready;

   mf3_frame_ctrl #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_frame_ctrl (
      .clock   (clock),
      .reset   (reset),
      .csr     (csr),
      .advance (req_accept),
      .col     (col),
      .flags   (flags)
   );

   // Read at accept, write back the shifted column when stage 1 moves on.
   // Consecutive pixels never share a column, so read and write never collide.
   assign line_wr = {s1_pix_ff, line_rd[2*PIX_W-1:PIX_W]};

   mf3_ram #(
      .WIDTH (2 * PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (col),
      .rd_data (line_rd),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (line_wr)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pix_ff  <= {req.chan2_in, req.chan1_in, req.chan0_in};
         s1_col_ff  <= col;
         s1_emit_ff <= flags.emit;
         s1_last_ff <= flags.last;
      end
   end

   // Window slides left; the new column is row-2 above, row-1 above, current.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         window_in[r*3 + 0] = window_ff[r*3 + 1];
         window_in[r*3 + 1] = window_ff[r*3 + 2];
      end
      window_in[2] = line_rd[PIX_W-1:0];
      window_in[5] = line_rd[2*PIX_W-1:PIX_W];
      window_in[8] = s1_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (flags.restart) begin
         window_ff <= '0;
      end else if (s1_adv) begin
         window_ff <= window_in;
      end
   end

   // Median is taken straight off the updated window.
   mf3_median u_median (
      .window    (window_in),
      .chan0_med (med0),
      .chan1_med (med1),
      .chan2_med (med2)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv && s1_emit_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_emit_ff) begin
         rsp_med0_ff <= med0;
         rsp_med1_ff <= med1;
         rsp_med2_ff <= med2;
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.chan0_med  = rsp_med0_ff;
   assign rsp.chan1_med  = rsp_med1_ff;
   assign rsp.chan2_med  = rsp_med2_ff;
   assign rsp.frame_last = rsp_last_ff;

   // An interior pixel leaving stage 1 always lands in the result register.
   `MF3_ASSERT_NEXT(a_emit_lands, clock, reset, s1_adv && s1_emit_ff, rsp_valid_ff)
   // End of frame can only be flagged on an interior pixel.
   `MF3_ASSERT_IMPL(a_last_is_interior, clock, reset, s1_valid_ff && s1_last_ff, s1_emit_ff)
   // A frame restart leaves an all-zero window.
   `MF3_ASSERT_NEXT(a_restart_clears, clock, reset, flags.restart, window_ff == '0)

endmodule

`default_nettype wire

>>> hdl/mf3_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mf3_ram #(
   parameter int unsigned WIDTH = 48,
   parameter int unsigned DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/mf3_frame_ctrl.sv
// Size registers, column/row counters and per-pixel position flags.
`default_nettype none

module mf3_frame_ctrl #(
   parameter int unsigned MAX_WIDTH = 2048
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   mf3_csr_if.sink                            csr,
   input  wire logic                          advance,
   output logic      [$clog2(MAX_WIDTH)-1:0]  col,
   output mf3_pkg::pos_flags_type             flags
);

   localparam int unsigned CW = $clog2(MAX_WIDTH);

   logic [mf3_pkg::WIDTH_W-1:0]  width_ff;
   logic [mf3_pkg::HEIGHT_W-1:0] height_ff;
   logic [CW-1:0]                col_ff, col_in;
   logic [mf3_pkg::ROW_W-1:0]    row_ff, row_in;
   logic [CW-1:0]                eff_w_m1;
   logic [mf3_pkg::ROW_W-1:0]    eff_h_m1;
   logic                         csr_write;
   logic                         restart;
   logic                         col_last;
   logic                         row_last;

   assign csr.ready = 1'b1;
   assign csr_write = csr.valid && csr.ready;
   assign restart   = csr_write &&
                      (csr.index == mf3_pkg::CSR_IMAGE_WIDTH ||
                       csr.index == mf3_pkg::CSR_IMAGE_HEIGHT);

   // Clamp sizes into their legal ranges, kept as "last index" values.
   always_comb begin
      if (width_ff < mf3_pkg::WIDTH_W'(mf3_pkg::MIN_DIM)) begin
         eff_w_m1 = CW'(mf3_pkg::MIN_DIM - 1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         eff_w_m1 = CW'(MAX_WIDTH - 1);
      end else begin
         eff_w_m1 = CW'(width_ff - 12'd1);
      end
      if (height_ff < mf3_pkg::HEIGHT_W'(mf3_pkg::MIN_DIM)) begin
         eff_h_m1 = mf3_pkg::ROW_W'(mf3_pkg::MIN_DIM - 1);
      end else if (32'(height_ff) > 32'(mf3_pkg::MAX_HEIGHT)) begin
         eff_h_m1 = mf3_pkg::ROW_W'(mf3_pkg::MAX_HEIGHT - 1);
      end else begin
         eff_h_m1 = mf3_pkg::ROW_W'(height_ff - 13'd1);
      end
   end

   assign col_last = (col_ff == eff_w_m1);
   assign row_last = (row_ff == eff_h_m1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (advance) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= mf3_pkg::WIDTH_RESET;
         height_ff <= mf3_pkg::HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (csr_write) begin
            unique case (csr.index)
               mf3_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr.data[mf3_pkg::WIDTH_W-1:0];
               mf3_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr.data[mf3_pkg::HEIGHT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   assign col           = col_ff;
   assign flags.emit    = (row_ff >= mf3_pkg::ROW_W'(2)) && (col_ff >= CW'(2));
   assign flags.last    = row_last && col_last;
   assign flags.restart = restart;

endmodule

`default_nettype wire

>>> hdl/mf3_median.sv
// Per-channel median of a 3x3 window, 19 compare-exchange network.
`default_nettype none

module mf3_median (
   input  wire mf3_pkg::window_type window,
   output logic [7:0]               chan0_med,
   output logic [7:0]               chan1_med,
   output logic [7:0]               chan2_med
);

   localparam int unsigned NCE = 19;
   localparam logic [3:0] PA [NCE] = '{4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6, 4'd1,
                                       4'd4, 4'd7, 4'd0, 4'd5, 4'd4, 4'd3, 4'd1,
                                       4'd2, 4'd4, 4'd4, 4'd6, 4'd4};
   localparam logic [3:0] PB [NCE] = '{4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd2,
                                       4'd5, 4'd8, 4'd3, 4'd8, 4'd7, 4'd6, 4'd4,
                                       4'd5, 4'd7, 4'd2, 4'd4, 4'd2};

   // Each step leaves the smaller value at PA, the larger at PB.
   function automatic logic [7:0] med9(input logic [8:0][7:0] v_in);
      logic [8:0][7:0] p;
      logic [7:0]      t;
      p = v_in;
      for (int i = 0; i < NCE; i++) begin
         if (p[PA[i]] > p[PB[i]]) begin
            t        = p[PA[i]];
            p[PA[i]] = p[PB[i]];
            p[PB[i]] = t;
         end
      end
      return p[mf3_pkg::MID_TAP];
   endfunction

   logic [2:0][8:0][7:0] chan_taps;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         for (int k = 0; k < mf3_pkg::TAPS; k++) begin
            chan_taps[c][k] = window[k][c*8 +: 8];
         end
      end
   end

   assign chan0_med = med9(chan_taps[0]);
   assign chan1_med = med9(chan_taps[1]);
   assign chan2_med = med9(chan_taps[2]);

endmodule

`default_nettype wire
